[rtl/bts_pkg.sv]
`default_nettype none
package bts_pkg;

   localparam logic [1:0] CMD_CLEAR = 2'd0;
   localparam logic [1:0] CMD_DRAW  = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   localparam logic [23:0] WHITE = 24'hFFFFFF;

   localparam int CRD_W = 10;  // signed coordinate difference
   localparam int EDG_W = 20;  // edge function, determinant, weights
   localparam int ACC_W = 32;  // accumulator and division remainder
   localparam int DIM_W = 13;  // clipped frame size

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_D0,
      ST_D1,
      ST_CHECK,
      ST_A0,
      ST_A1,
      ST_B0,
      ST_B1,
      ST_TEST,
      ST_MAC0,
      ST_MAC1,
      ST_MAC2,
      ST_DIV,
      ST_WRITE
   } state_type;

endpackage
`default_nettype wire

[rtl/barycentric_triangle_shader.sv]
`default_nettype none
// read: RAM output, then result register, held while it is busy; clear: one pixel a cycle
// draw: setup states D0, D1 and CHECK, then per box pixel the edge states A0 to B1 and TEST;
// inside the triangle three multiply-accumulates and 8 restoring division steps per channel on one
// shared multiplier and subtractor, then WRITE; a degenerate triangle writes one pixel a cycle
// throughput: one command at a time, req_tready low while a command is in work
// reset: synchronous; a clearing pass over all MAX_WIDTH*MAX_HEIGHT pixels paints the store white
module barycentric_triangle_shader #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   // vertex0_x, vertex0_y, vertex1_x, vertex1_y, vertex2_x, vertex2_y,
   // vertex0_color, vertex1_color, vertex2_color, read_x, read_y
   input  wire  [135:0] req_tdata,
   // command
   input  wire  [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   // pixel_color
   output logic [23:0]  rsp_tdata,
   input  wire          csr_psel,
   input  wire          csr_penable,
   input  wire          csr_pwrite,
   input  wire  [2:0]   csr_paddr,
   input  wire  [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   import bts_pkg::*;

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = $clog2(DEPTH);

   state_type state_ff, state_in;

   logic [8:0]  width_ff, height_ff;
   logic [AW-1:0] clr_ff, clr_in;
   logic [7:0]  x0_ff, y0_ff, x1_ff, y1_ff, x2_ff, y2_ff;
   logic [7:0]  x0_in, y0_in, x1_in, y1_in, x2_in, y2_in;
   logic [23:0] c0_ff, c1_ff, c2_ff, c0_in, c1_in, c2_in;
   logic [7:0]  x_ff, y_ff, xlo_ff, xhi_ff, yhi_ff;
   logic [7:0]  x_in, y_in, xlo_in, xhi_in, yhi_in;
   logic        empty_ff, empty_in;
   logic        dneg_ff, dneg_in, dzero_ff, dzero_in;
   logic signed [EDG_W-1:0] dd_ff, dd_in, a_ff, a_in, b_ff, b_in, g_ff, g_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in, rem_ff, rem_in;
   logic [1:0]  ch_ff, ch_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic [23:0] color_ff, color_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [23:0] rsp_data_ff, rsp_data_in;
   logic        oob_ff, oob_in;
   logic [AW-1:0] raddr_ff, raddr_in;

   logic        accept;
   logic        rsp_free;
   logic [7:0]  f_x0, f_y0, f_x1, f_y1, f_x2, f_y2, f_rx, f_ry;
   logic [7:0]  bx_lo, bx_hi, by_lo, by_hi, xhi_c, yhi_c;
   logic [DIM_W-1:0] w_use, h_use;
   logic        box_empty;

   logic signed [CRD_W-1:0] ax, bx, ay, by, vx, vy;
   logic signed [EDG_W-1:0] opa;
   logic signed [CRD_W-1:0] opb;
   logic signed [EDG_W+CRD_W-1:0] prod;
   logic        mac_start, mac_sub;
   logic signed [ACC_W-1:0] mac_sum, dshift, trial;
   logic signed [EDG_W-1:0] an, bn, gn;
   logic        last_x, last_y;

   logic          ram_we;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [23:0]   ram_wdata, ram_rdata;

   assign f_x0 = req_tdata[7:0];
   assign f_y0 = req_tdata[15:8];
   assign f_x1 = req_tdata[23:16];
   assign f_y1 = req_tdata[31:24];
   assign f_x2 = req_tdata[39:32];
   assign f_y2 = req_tdata[47:40];
   assign f_rx = req_tdata[127:120];
   assign f_ry = req_tdata[135:128];

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   // result register is free or is being emptied this cycle
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = csr_paddr[2] ? {23'd0, height_ff} : {23'd0, width_ff};

   // bounding box and clipping
   always_comb begin
      bx_lo = (f_x0 < f_x1) ? f_x0 : f_x1;
      bx_lo = (bx_lo < f_x2) ? bx_lo : f_x2;
      bx_hi = (f_x0 > f_x1) ? f_x0 : f_x1;
      bx_hi = (bx_hi > f_x2) ? bx_hi : f_x2;
      by_lo = (f_y0 < f_y1) ? f_y0 : f_y1;
      by_lo = (by_lo < f_y2) ? by_lo : f_y2;
      by_hi = (f_y0 > f_y1) ? f_y0 : f_y1;
      by_hi = (by_hi > f_y2) ? by_hi : f_y2;
      w_use = (DIM_W'(width_ff) > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : DIM_W'(width_ff);
      h_use = (DIM_W'(height_ff) > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT)
                                                        : DIM_W'(height_ff);
      xhi_c = (DIM_W'(bx_hi) > w_use - DIM_W'(1)) ? 8'(w_use - DIM_W'(1)) : bx_hi;
      yhi_c = (DIM_W'(by_hi) > h_use - DIM_W'(1)) ? 8'(h_use - DIM_W'(1)) : by_hi;
      box_empty = (w_use == '0) || (h_use == '0) || (bx_lo > xhi_c) || (by_lo > yhi_c);
   end

   assign ax = CRD_W'({2'b00, x0_ff}) - CRD_W'({2'b00, x2_ff});
   assign bx = CRD_W'({2'b00, x1_ff}) - CRD_W'({2'b00, x2_ff});
   assign ay = CRD_W'({2'b00, y0_ff}) - CRD_W'({2'b00, y2_ff});
   assign by = CRD_W'({2'b00, y1_ff}) - CRD_W'({2'b00, y2_ff});
   assign vx = CRD_W'({2'b00, x_ff}) - CRD_W'({2'b00, x2_ff});
   assign vy = CRD_W'({2'b00, y_ff}) - CRD_W'({2'b00, y2_ff});

   // shared multiply-accumulate operand selection
   always_comb begin
      opa       = '0;
      opb       = '0;
      mac_start = 1'b0;
      mac_sub   = 1'b0;
      case (state_ff)
         ST_D0: begin
            opa = EDG_W'(ax); opb = by; mac_start = 1'b1;
         end
         ST_D1: begin
            opa = EDG_W'(bx); opb = ay; mac_sub = 1'b1;
         end
         ST_A0: begin
            opa = EDG_W'(by); opb = vx; mac_start = 1'b1;
         end
         ST_A1: begin
            opa = EDG_W'(bx); opb = vy; mac_sub = 1'b1;
         end
         ST_B0: begin
            opa = EDG_W'(ax); opb = vy; mac_start = 1'b1;
         end
         ST_B1: begin
            opa = EDG_W'(ay); opb = vx; mac_sub = 1'b1;
         end
         ST_MAC0: begin
            opa = a_ff; opb = CRD_W'({2'b00, c0_ff[ch_ff*8 +: 8]}); mac_start = 1'b1;
         end
         ST_MAC1: begin
            opa = b_ff; opb = CRD_W'({2'b00, c1_ff[ch_ff*8 +: 8]});
         end
         ST_MAC2: begin
            opa = g_ff; opb = CRD_W'({2'b00, c2_ff[ch_ff*8 +: 8]});
         end
         default: begin
            opa = '0;
         end
      endcase
   end

   assign prod    = opa * opb;
   assign mac_sum = (mac_start ? ACC_W'(0) : acc_ff)
                  + (mac_sub ? -ACC_W'(prod) : ACC_W'(prod));
   assign dshift  = ACC_W'(dd_ff) <<< ({1'b0, cnt_ff} + 4'd1);
   assign trial   = rem_ff - dshift;

   assign an = dneg_ff ? -a_ff : a_ff;
   assign bn = dneg_ff ? -b_ff : b_ff;
   assign gn = dd_ff - an - bn;

   assign last_x = (x_ff == xhi_ff);
   assign last_y = (y_ff == yhi_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == AW'(DEPTH - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               case (req_tuser)
                  CMD_CLEAR: state_in = ST_CLEAR;
                  CMD_DRAW:  state_in = ST_D0;
                  CMD_READ:  state_in = ST_READ;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_READ: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         ST_D0:    state_in = ST_D1;
         ST_D1:    state_in = ST_CHECK;
         ST_CHECK: begin
            if (empty_ff) state_in = ST_IDLE;
            else if (dzero_ff) state_in = ST_WRITE;
            else state_in = ST_A0;
         end
         ST_A0: state_in = ST_A1;
         ST_A1: state_in = ST_B0;
         ST_B0: state_in = ST_B1;
         ST_B1: state_in = ST_TEST;
         ST_TEST: begin
            if (an[EDG_W-1] || bn[EDG_W-1] || gn[EDG_W-1]) begin
               state_in = (last_x && last_y) ? ST_IDLE : ST_A0;
            end else begin
               state_in = ST_MAC0;
            end
         end
         ST_MAC0: state_in = ST_MAC1;
         ST_MAC1: state_in = ST_MAC2;
         ST_MAC2: state_in = ST_DIV;
         ST_DIV: begin
            if (cnt_ff == 3'd0) state_in = (ch_ff == 2'd2) ? ST_WRITE : ST_MAC0;
         end
         ST_WRITE: begin
            if (last_x && last_y) state_in = ST_IDLE;
            else state_in = dzero_ff ? ST_WRITE : ST_A0;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath next values
   always_comb begin
      clr_in      = clr_ff;
      x0_in = x0_ff; y0_in = y0_ff; x1_in = x1_ff; y1_in = y1_ff;
      x2_in = x2_ff; y2_in = y2_ff;
      c0_in = c0_ff; c1_in = c1_ff; c2_in = c2_ff;
      x_in = x_ff; y_in = y_ff; xlo_in = xlo_ff; xhi_in = xhi_ff; yhi_in = yhi_ff;
      empty_in    = empty_ff;
      dneg_in     = dneg_ff;
      dzero_in    = dzero_ff;
      dd_in       = dd_ff;
      a_in        = a_ff;
      b_in        = b_ff;
      g_in        = g_ff;
      acc_in      = acc_ff;
      rem_in      = rem_ff;
      ch_in       = ch_ff;
      cnt_in      = cnt_ff;
      color_in    = color_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      oob_in      = oob_ff;
      raddr_in    = raddr_ff;
      ram_we      = 1'b0;
      ram_waddr   = AW'(32'(y_ff) * MAX_WIDTH + 32'(x_ff));
      ram_wdata   = color_ff;
      ram_raddr   = AW'(32'(f_ry) * MAX_WIDTH + 32'(f_rx));

      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = WHITE;
            clr_in    = clr_ff + AW'(1);
         end
         ST_IDLE: begin
            clr_in = '0;
            if (accept) begin
               x0_in = f_x0; y0_in = f_y0; x1_in = f_x1; y1_in = f_y1;
               x2_in = f_x2; y2_in = f_y2;
               c0_in = req_tdata[71:48];
               c1_in = req_tdata[95:72];
               c2_in = req_tdata[119:96];
               x_in = bx_lo; y_in = by_lo; xlo_in = bx_lo;
               xhi_in = xhi_c; yhi_in = yhi_c;
               empty_in = box_empty;
               oob_in = (32'(f_rx) >= MAX_WIDTH) || (32'(f_ry) >= MAX_HEIGHT);
               raddr_in = ram_raddr;
            end
         end
         ST_READ: begin
            // keep the read address so the data stays put while the result register is busy
            ram_raddr = raddr_ff;
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = oob_ff ? WHITE : ram_rdata;
            end
         end
         ST_D0: acc_in = mac_sum;
         ST_D1: begin
            dneg_in  = mac_sum[ACC_W-1];
            dzero_in = (mac_sum == '0);
            dd_in    = mac_sum[ACC_W-1] ? -EDG_W'(mac_sum) : EDG_W'(mac_sum);
         end
         ST_CHECK: color_in = c2_ff;
         ST_A0: acc_in = mac_sum;
         ST_A1: a_in = EDG_W'(mac_sum);
         ST_B0: acc_in = mac_sum;
         ST_B1: b_in = EDG_W'(mac_sum);
         ST_TEST: begin
            a_in     = an;
            b_in     = bn;
            g_in     = gn;
            ch_in    = 2'd0;
            color_in = '0;
            // pixel outside: step to the next one without a write
            if (an[EDG_W-1] || bn[EDG_W-1] || gn[EDG_W-1]) begin
               if (last_x) begin
                  x_in = xlo_ff;
                  y_in = y_ff + 8'd1;
               end else begin
                  x_in = x_ff + 8'd1;
               end
            end
         end
         ST_MAC0: acc_in = mac_sum;
         ST_MAC1: acc_in = mac_sum;
         ST_MAC2: begin
            rem_in = (mac_sum <<< 1) + ACC_W'(dd_ff);
            cnt_in = 3'd7;
         end
         ST_DIV: begin
            if (!trial[ACC_W-1]) begin
               rem_in = trial;
               color_in[{ch_ff, cnt_ff}] = 1'b1;
            end
            cnt_in = cnt_ff - 3'd1;
            if (cnt_ff == 3'd0) ch_in = ch_ff + 2'd1;
         end
         ST_WRITE: begin
            ram_we = 1'b1;
            if (last_x) begin
               x_in = xlo_ff;
               y_in = y_ff + 8'd1;
            end else begin
               x_in = x_ff + 8'd1;
            end
         end
         default: begin
            ram_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         width_ff     <= 9'd256;
         height_ff    <= 9'd256;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[2]) height_ff <= csr_pwdata[8:0];
            else width_ff <= csr_pwdata[8:0];
         end
      end
      x0_ff <= x0_in; y0_ff <= y0_in; x1_ff <= x1_in; y1_ff <= y1_in;
      x2_ff <= x2_in; y2_ff <= y2_in;
      c0_ff <= c0_in; c1_ff <= c1_in; c2_ff <= c2_in;
      x_ff <= x_in; y_ff <= y_in; xlo_ff <= xlo_in; xhi_ff <= xhi_in; yhi_ff <= yhi_in;
      empty_ff    <= empty_in;
      dneg_ff     <= dneg_in;
      dzero_ff    <= dzero_in;
      dd_ff       <= dd_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      g_ff        <= g_in;
      acc_ff      <= acc_in;
      rem_ff      <= rem_in;
      ch_ff       <= ch_in;
      cnt_ff      <= cnt_in;
      color_ff    <= color_in;
      rsp_data_ff <= rsp_data_in;
      oob_ff      <= oob_in;
      raddr_ff    <= raddr_in;
   end

   bts_ram #(
      .WIDTH(24),
      .DEPTH(DEPTH)
   ) u_frame (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

endmodule
`default_nettype wire

[rtl/bts_ram.sv]
`default_nettype none
module bts_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 65536
) (
   input  wire                       clock,
   input  wire                       we,
   input  wire  [$clog2(DEPTH)-1:0]  waddr,
   input  wire  [WIDTH-1:0]          wdata,
   input  wire  [$clog2(DEPTH)-1:0]  raddr,
   output logic [WIDTH-1:0]          rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule
`default_nettype wire
